### hw/rtl/hdm_pkg.sv
package hdm_pkg;

   localparam int HASH_BYTES = 28;
   localparam int HASH_W     = HASH_BYTES * 8;
   localparam int NIBBLES    = HASH_BYTES * 2;
   localparam int MAX_BITS   = NIBBLES * 7;
   localparam int MIN_BITS   = NIBBLES * 6;
   localparam int POS_W      = $clog2(MAX_BITS);
   localparam int GROUP      = 28;
   localparam int GROUPS     = MAX_BITS / GROUP;
   localparam int GIDX_W     = $clog2(GROUP);
   localparam int GSEL_W     = $clog2(GROUPS);

   localparam logic [7:0] CHAR_DIGIT  = 8'h30;
   localparam logic [7:0] CHAR_LETTER = 8'h57;
   localparam logic [3:0] NIB_NINE    = 4'h9;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFICULTY = 3'd4;

   // bit i of a string is the i-th expanded bit
   typedef logic [MAX_BITS-1:0] hdm_bits_type;

   typedef struct packed {
      hdm_bits_type     bits;
      logic [POS_W-1:0] len;
   } hdm_exp_type;

   function automatic hdm_exp_type hdm_expand(input logic [HASH_W-1:0] h);
      logic [NIBBLES-1:0] letter;
      logic [3:0]         v;
      logic [6:0]         ch;
      logic [6:0]         rev;
      logic [2:0]         w;
      logic [POS_W-1:0]   off;
      hdm_exp_type        r;
      for (int j = 0; j < NIBBLES; j++) begin
         letter[j] = h[HASH_W-1-4*j -: 4] > NIB_NINE;
      end
      r.bits = '0;
      for (int j = 0; j < NIBBLES; j++) begin
         v   = h[HASH_W-1-4*j -: 4];
         ch  = letter[j] ? 7'(CHAR_LETTER + {4'd0, v}) : 7'(CHAR_DIGIT + {4'd0, v});
         w   = letter[j] ? 3'd7 : 3'd6;
         for (int i = 0; i < 7; i++) begin
            rev[i] = (3'(i) < w) ? ch[3'(w - 3'(1) - 3'(i))] : 1'b0;
         end
         // offset is six per nibble plus one per earlier letter
         off = POS_W'(6 * j) +
               POS_W'($countones(letter & ((NIBBLES'(1) << j) - NIBBLES'(1))));
         r.bits = r.bits | (hdm_bits_type'(rev) << off);
      end
      r.len = POS_W'(MIN_BITS) + POS_W'($countones(letter));
      return r;
   endfunction

endpackage

### hw/rtl/hdm_req_if.sv
interface hdm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_word0;
   logic [63:0] hash_word1;
   logic [63:0] hash_word2;
   logic [31:0] hash_word3;

   modport source (output valid, hash_word0, hash_word1, hash_word2, hash_word3,
                   input ready);
   modport sink (input valid, hash_word0, hash_word1, hash_word2, hash_word3,
                 output ready);
endinterface

### hw/rtl/hdm_rsp_if.sv
interface hdm_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [8:0] match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink (input valid, found, match_position, output ready);
endinterface

### hw/rtl/hdm_search.sv
module hdm_search
   import hdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hdm_exp_type      hay,
   input  hdm_bits_type     needle,
   input  hdm_bits_type     mask,
   input  logic [POS_W-1:0] nlen,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_found,
   output logic [POS_W-1:0] out_pos
);

   logic                     a_valid_ff, b_valid_ff, c_valid_ff;
   logic                     en_a, en_b, en_c;
   logic [MAX_BITS-1:0]      hit_ff, hit_in;
   logic [GROUPS-1:0]        gany_ff, gany_in;
   logic [GIDX_W-1:0]        gidx_ff [GROUPS];
   logic [GIDX_W-1:0]        gidx_in [GROUPS];
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         pos_ff, pos_in;

   assign en_c     = out_ready || !c_valid_ff;
   assign en_b     = en_c || !b_valid_ff;
   assign en_a     = en_b || !a_valid_ff;
   assign in_ready = en_a;

   // one compare per start position
   always_comb begin
      for (int p = 0; p < MAX_BITS; p++) begin
         hit_in[p] = ((POS_W+1)'(p) + {1'b0, nlen} <= {1'b0, hay.len}) &&
                     ((((hay.bits >> p) ^ needle) & mask) == '0);
      end
   end

   // first hit inside each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         gany_in[g] = |hit_ff[g*GROUP +: GROUP];
         gidx_in[g] = '0;
         for (int i = GROUP - 1; i >= 0; i--) begin
            if (hit_ff[g*GROUP + i]) begin
               gidx_in[g] = GIDX_W'(i);
            end
         end
      end
   end

   always_comb begin
      logic [GSEL_W-1:0] gsel;
      gsel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (gany_ff[g]) begin
            gsel = GSEL_W'(g);
         end
      end
      found_in = |gany_ff;
      pos_in   = found_in ?
                 POS_W'(POS_W'(gsel) * POS_W'(GROUP)) + POS_W'(gidx_ff[gsel]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= in_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
      end
      if (en_a) hit_ff <= hit_in;
      if (en_b) begin
         gany_ff <= gany_in;
         gidx_ff <= gidx_in;
      end
      if (en_c) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_found = found_ff;
   assign out_pos   = pos_ff;

endmodule

### hw/rtl/hexbin_difficulty_match_unit.sv
// hexbin difficulty match: checks one candidate hash against a configured target.
// req_ch carries a 224-bit candidate hash; rsp_ch returns found and the first bit
// offset of the needle in the hex-binary expansion of the candidate.
// the needle is the expanded target cut to difficulty_bits bits (at most its full length); write target
// words and difficulty through the csr port (index 0..4) while no transaction is
// in flight. derived needle and mask are registered from the csr registers.
// pipeline: expand stage, per-position compare stage, group priority stage and
// output register. one transaction is taken per cycle while the pipe is not
// stalled; each stage holds a valid bit and moves when the next stage is free,
// so a stalled rsp_ch fills the pipe and then drops req_ch.ready, losing
// nothing. synchronous reset empties the pipeline and clears the configuration
// to zero (empty needle, match at position 0).
module hexbin_difficulty_match_unit
   import hdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   hdm_req_if.sink              req_ch,
   hdm_rsp_if.source            rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   logic [63:0]      target0_ff, target1_ff, target2_ff;
   logic [31:0]      target3_ff;
   logic [POS_W-1:0] difficulty_ff;
   hdm_bits_type     needle_ff, needle_in, mask_ff, mask_in;
   logic [POS_W-1:0] nlen_ff, nlen_in;
   hdm_exp_type      hay_ff, hay_in, texp;
   logic             s1_valid_ff;
   logic             s1_en, search_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target0_ff    <= '0;
         target1_ff    <= '0;
         target2_ff    <= '0;
         target3_ff    <= '0;
         difficulty_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET0:    target0_ff    <= csr_data;
            CSR_TARGET1:    target1_ff    <= csr_data;
            CSR_TARGET2:    target2_ff    <= csr_data;
            CSR_TARGET3:    target3_ff    <= csr_data[31:0];
            CSR_DIFFICULTY: difficulty_ff <= csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      texp      = hdm_expand({target0_ff, target1_ff, target2_ff, target3_ff});
      nlen_in   = (difficulty_ff > texp.len) ? texp.len : difficulty_ff;
      mask_in   = ~({MAX_BITS{1'b1}} << nlen_in);
      needle_in = texp.bits & mask_in;
      hay_in    = hdm_expand({req_ch.hash_word0, req_ch.hash_word1,
                              req_ch.hash_word2, req_ch.hash_word3});
   end

   assign s1_en        = search_ready || !s1_valid_ff;
   assign req_ch.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (s1_en) hay_ff <= hay_in;
      needle_ff <= needle_in;
      mask_ff   <= mask_in;
      nlen_ff   <= nlen_in;
   end

   hdm_search u_search (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (search_ready),
      .hay       (hay_ff),
      .needle    (needle_ff),
      .mask      (mask_ff),
      .nlen      (nlen_ff),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_found (rsp_ch.found),
      .out_pos   (rsp_ch.match_position)
   );

endmodule

### dv/hexbin_difficulty_match_unit_test.sv
module hexbin_difficulty_match_unit_test;
   import hdm_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic             found;
      logic [POS_W-1:0] position;
   } match_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_data;

   hdm_req_if req_ch();
   hdm_rsp_if rsp_ch();

   hexbin_difficulty_match_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   logic [HASH_W-1:0] target_hash;
   logic [8:0]        difficulty;
   match_result_type  pending_matches[$];
   int                errors;
   bit                sender_steady;
   bit                receiver_steady;
   int                rsp_hold_cycles;
   int                quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hex-ascii expansion, bit i is the i-th bit of the string
   function automatic void expand_hex_bits(input logic [HASH_W-1:0] h,
                                           output logic [MAX_BITS-1:0] bits,
                                           output int len);
      logic [3:0] v;
      logic [6:0] ch;
      int         w;
      bits = '0;
      len  = 0;
      for (int j = 0; j < NIBBLES; j++) begin
         v = h[HASH_W-1-4*j -: 4];
         if (v < 4'd10) begin
            ch = 7'h30 + v;
            w  = 6;
         end else begin
            ch = 7'h57 + v;
            w  = 7;
         end
         for (int i = 0; i < w; i++) bits[len+i] = ch[w-1-i];
         len += w;
      end
   endfunction

   function automatic match_result_type predict_match(input logic [HASH_W-1:0] h);
      logic [MAX_BITS-1:0] hay;
      logic [MAX_BITS-1:0] needle;
      int                  hlen;
      int                  tlen;
      int                  n;
      bit                  hit;
      match_result_type    r;
      expand_hex_bits(h, hay, hlen);
      expand_hex_bits(target_hash, needle, tlen);
      n = difficulty;
      if (n > tlen) n = tlen;
      r.found    = 1'b0;
      r.position = '0;
      if (n == 0) begin
         r.found = 1'b1;
      end else begin
         for (int p = 0; p + n <= hlen && !r.found; p++) begin
            hit = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (hay[p+i] !== needle[i]) begin
                  hit = 1'b0;
                  break;
               end
            end
            if (hit) begin
               r.found    = 1'b1;
               r.position = POS_W'(p);
            end
         end
      end
      return r;
   endfunction

   function automatic logic [HASH_W-1:0] random_hash();
      logic [HASH_W-1:0] h;
      for (int i = 0; i < HASH_W / 32; i++) h[32*i +: 32] = $urandom;
      return h;
   endfunction

   // candidate shaped so that the needle shows up often
   function automatic logic [HASH_W-1:0] shaped_hash();
      logic [HASH_W-1:0] h;
      int                k;
      logic [3:0]        base;
      h = random_hash();
      case ($urandom_range(0, 4))
         0: ;
         1: h = target_hash;
         2: begin
            k = $urandom_range(0, HASH_BYTES - 1);
            for (int b = 0; b + k < HASH_BYTES; b++)
               h[HASH_W-1-8*(b+k) -: 8] = target_hash[HASH_W-1-8*b -: 8];
         end
         default: begin
            base = $urandom_range(0, 1) ? 4'h0 : 4'ha;
            for (int j = 0; j < NIBBLES; j++)
               h[4*j +: 4] = base + 4'($urandom_range(0, 1));
         end
      endcase
      return h;
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      case (idx)
         CSR_TARGET0:    target_hash[223:160] = data;
         CSR_TARGET1:    target_hash[159:96]  = data;
         CSR_TARGET2:    target_hash[95:32]   = data;
         CSR_TARGET3:    target_hash[31:0]    = data[31:0];
         CSR_DIFFICULTY: difficulty           = data[8:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // idle between phases: every result in, then the pipe latency
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [HASH_W-1:0] tgt, input int diff);
      drain();
      write_register(CSR_TARGET0, tgt[223:160]);
      write_register(CSR_TARGET1, tgt[159:96]);
      write_register(CSR_TARGET2, tgt[95:32]);
      write_register(CSR_TARGET3, {32'($urandom), tgt[31:0]});
      write_register(CSR_DIFFICULTY, {55'({$urandom, $urandom}), 9'(diff)});
      repeat (2) @(posedge clock);
   endtask

   task automatic send_hash(input logic [HASH_W-1:0] h);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.hash_word0 <= h[223:160];
      req_ch.hash_word1 <= h[159:96];
      req_ch.hash_word2 <= h[95:32];
      req_ch.hash_word3 <= h[31:0];
      req_ch.valid      <= 1'b1;
      pending_matches.push_back(predict_match(h));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic test_reset_state();
      // cleared configuration means an empty needle
      send_hash('0);
      send_hash({HASH_W{1'b1}});
      send_hash(random_hash());
      drain();
   endtask

   task automatic test_directed_cases();
      logic [HASH_W-1:0] t;
      configure('0, 392);          // difficulty too long, clamps to 336
      send_hash('0);
      send_hash({HASH_W{1'b1}});
      configure({HASH_W{1'b1}}, 392);
      send_hash('0);               // needle longer than haystack
      send_hash({HASH_W{1'b1}});
      configure({HASH_W{1'b1}}, 7);
      send_hash('0);               // not found
      send_hash({{HASH_W-4{1'b0}}, 4'hf});
      configure('0, 1);
      send_hash({HASH_W{1'b1}});
      send_hash('0);
      t = random_hash();
      configure(t, 391);
      send_hash(t);
      send_hash(random_hash());
      configure(t, 0);
      send_hash(random_hash());
      configure(t, 20);
      send_hash({8'h00, t[HASH_W-1:8]});
      send_hash(random_hash());
      drain();
   endtask

   task automatic test_register_index();
      logic [HASH_W-1:0] t;
      t = random_hash();
      configure(t, 12);
      // writes past the last register change nothing
      for (int k = 1; k <= 3; k++)
         write_register(CSR_IDX_W'(CSR_DIFFICULTY + k), {$urandom, $urandom});
      repeat (2) @(posedge clock);
      for (int i = 0; i < 6; i++) send_hash(shaped_hash());
      drain();
   endtask

   task automatic test_random_phases();
      int diff;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 9))
            0:       diff = 0;
            1:       diff = 392;
            2:       diff = $urandom_range(336, 392);
            3:       diff = $urandom_range(49, 335);
            default: diff = $urandom_range(1, 48);
         endcase
         configure(random_hash(), diff);
         sender_steady   = (phase % 3 == 1);
         receiver_steady = (phase % 4 == 2);
         for (int i = 0; i < 250; i++) send_hash(shaped_hash());
         drain();
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      configure(random_hash(), $urandom_range(1, 30));
      sender_steady   = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 60; i++) send_hash(shaped_hash());
      sender_steady = 1'b0;
      drain();
      for (int i = 0; i < 20; i++) send_hash(shaped_hash());
      drain();
   endtask

   initial begin
      reset              = 1'b1;
      errors             = 0;
      sender_steady      = 1'b0;
      receiver_steady    = 1'b0;
      rsp_hold_cycles    = 0;
      target_hash        = '0;
      difficulty         = '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= '0;
      csr_data          <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.hash_word0 <= '0;
      req_ch.hash_word1 <= '0;
      req_ch.hash_word2 <= '0;
      req_ch.hash_word3 <= '0;
      rsp_ch.ready      <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_cases();
      test_register_index();
      test_random_phases();
      test_backpressure();
      if (errors == 0) begin
         $display("hexbin_difficulty_match_unit regression: pass");
      end else begin
         $display("hexbin_difficulty_match_unit regression: fail");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int               gap;
      match_result_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            gap = receiver_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_matches.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction found=%b position=%0d", $time,
                     rsp_ch.found, rsp_ch.match_position);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_ch.found !== want.found) begin
               errors++;
               $display("%0t: found expected %b actual %b", $time, want.found, rsp_ch.found);
            end
            if (rsp_ch.match_position !== want.position) begin
               errors++;
               $display("%0t: match_position expected %0d actual %0d", $time,
                        want.position, rsp_ch.match_position);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("hexbin_difficulty_match_unit regression: fail");
            $finish;
         end
      end
   end

   initial quiet_cycles = 0;

endmodule
